// ----- hw/rtl/occupancy_grid_ray_update_unit_assert.svh -----
// Assertion macros for the occupancy grid ray update port checker
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define OGRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ogru assertion failed");

// next-cycle implication, off while reset is asserted
`define OGRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ogru assertion failed");

`endif

// ----- hw/rtl/ogru_pkg.sv -----
// Types, constants and helpers for the occupancy grid ray update unit
package ogru_pkg;

  localparam int unsigned GridDim   = 256;
  localparam int unsigned GridDepth = GridDim * GridDim;
  localparam int unsigned AddrW     = $clog2(GridDepth);
  localparam int unsigned IdxW      = $clog2(GridDim);

  localparam int unsigned StartW  = 8;
  localparam int unsigned EndW    = 11;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned DeltaW  = 11;
  localparam int unsigned ErrW    = 13;
  localparam int unsigned OddsW   = 8;
  localparam int unsigned StepW   = 7;
  localparam int unsigned CntW    = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegHitStep  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMissStep = CfgIdxW'(1);

  localparam logic [StepW-1:0] HitStepRst  = StepW'(3);
  localparam logic [StepW-1:0] MissStepRst = StepW'(1);

  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic signed [OddsW:0] OddsMax = (OddsW+1)'(127);
  localparam logic signed [OddsW:0] OddsMin = -(OddsW+1)'(128);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_SETUP    = 8'b0000_0100,
    S_END_WR   = 8'b0000_1000,
    S_RAY_CHK  = 8'b0001_0000,
    S_RAY_WR   = 8'b0010_0000,
    S_READ_CAP = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    SelWalk  = 2'd0,
    SelEnd   = 2'd1,
    SelStart = 2'd2
  } addr_sel_e;

  typedef struct packed {
    logic      clear_wr;
    logic      load;
    logic      setup;
    addr_sel_e addr_sel;
    logic      end_wr;
    logic      ray_wr;
    logic      step;
    logic      read_cap;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_read;
    logic beyond;
    logic sel_in_grid;
    logic walk_at_end;
    logic out_free;
  } status_t;

  function automatic logic in_grid(logic signed [CoordW-1:0] x,
                                   logic signed [CoordW-1:0] y);
    logic signed [CoordW-1:0] lim;
    lim = $signed(CoordW'(GridDim));
    return !x[CoordW-1] && (x < lim) && !y[CoordW-1] && (y < lim);
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(logic signed [CoordW-1:0] x,
                                                 logic signed [CoordW-1:0] y);
    logic [AddrW-1:0] row;
    logic [AddrW-1:0] col;
    row = AddrW'(y[IdxW-1:0]);
    col = AddrW'(x[IdxW-1:0]);
    return row * AddrW'(GridDim) + col;
  endfunction

endpackage

// ----- hw/rtl/occupancy_grid_ray_update_unit.sv -----
// Top level of the occupancy grid ray update unit
// Read transaction: SETUP, READ_CAP, then RESULT; ignored ray: SETUP, then RESULT.
// Ray transaction: SETUP, END_WR for an in-grid endpoint, RAY_CHK and RAY_WR (a grid memory
//   read-modify-write) per in-grid ray cell, RAY_CHK alone per off-grid cell, then RESULT.
// One transaction at a time; the next is taken once the result is in the output register.
// After reset all GridDepth cells are zeroed, one cell a cycle, before input is taken.
module occupancy_grid_ray_update_unit import ogru_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [StepW-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     in_req_type_i,
  input  logic [StartW-1:0]        in_start_x_i,
  input  logic [StartW-1:0]        in_start_y_i,
  input  logic signed [EndW-1:0]   in_end_x_i,
  input  logic signed [EndW-1:0]   in_end_y_i,
  input  logic                     in_ray_beyond_max_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OddsW-1:0]  out_read_odds_o,
  output logic [CntW-1:0]          out_cells_cleared_o,
  output logic                     out_endpoint_scored_o
);

  cmd_t    cmd;
  status_t status;

  ogru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ogru_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_req_type_i         (in_req_type_i),
    .in_start_x_i          (in_start_x_i),
    .in_start_y_i          (in_start_y_i),
    .in_end_x_i            (in_end_x_i),
    .in_end_y_i            (in_end_y_i),
    .in_ray_beyond_max_i   (in_ray_beyond_max_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_read_odds_o       (out_read_odds_o),
    .out_cells_cleared_o   (out_cells_cleared_o),
    .out_endpoint_scored_o (out_endpoint_scored_o)
  );

endmodule

// ----- hw/rtl/ogru_ctrl.sv -----
// Sequencer for the clearing pass, ray walk and cell read
module ogru_ctrl import ogru_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.addr_sel = SelWalk;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup    = 1'b1;
        cmd_o.addr_sel = status_i.req_read ? SelStart : SelEnd;
        if (status_i.req_read) begin
          state_d = S_READ_CAP;
        end else if (status_i.beyond) begin
          state_d = S_RESULT;
        end else if (status_i.sel_in_grid) begin
          state_d = S_END_WR;
        end else begin
          state_d = S_RAY_CHK;
        end
      end
      S_END_WR: begin
        cmd_o.addr_sel = SelEnd;
        cmd_o.end_wr   = 1'b1;
        state_d        = S_RAY_CHK;
      end
      S_RAY_CHK: begin
        if (status_i.walk_at_end) begin
          state_d = S_RESULT;
        end else if (status_i.sel_in_grid) begin
          state_d = S_RAY_WR;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_RAY_WR: begin
        cmd_o.ray_wr = 1'b1;
        cmd_o.step   = 1'b1;
        state_d      = S_RAY_CHK;
      end
      S_READ_CAP: begin
        cmd_o.addr_sel = SelStart;
        cmd_o.read_cap = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/ogru_dp.sv -----
// Datapath: grid memory, line stepper, step registers and result register
module ogru_dp import ogru_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [StepW-1:0]         cfg_data_i,
  input  logic                     in_req_type_i,
  input  logic [StartW-1:0]        in_start_x_i,
  input  logic [StartW-1:0]        in_start_y_i,
  input  logic signed [EndW-1:0]   in_end_x_i,
  input  logic signed [EndW-1:0]   in_end_y_i,
  input  logic                     in_ray_beyond_max_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OddsW-1:0]  out_read_odds_o,
  output logic [CntW-1:0]          out_cells_cleared_o,
  output logic                     out_endpoint_scored_o
);

  logic [StepW-1:0] hit_q, miss_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= HitStepRst;
      miss_q <= MissStepRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHitStep:  hit_q  <= cfg_data_i;
        RegMissStep: miss_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                   req_q, beyond_q;
  logic [StartW-1:0]      x0_q, y0_q;
  logic signed [EndW-1:0] x1_q, y1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= in_req_type_i;
      beyond_q <= in_ray_beyond_max_i;
      x0_q     <= in_start_x_i;
      y0_q     <= in_start_y_i;
      x1_q     <= in_end_x_i;
      y1_q     <= in_end_y_i;
    end
  end

  logic signed [CoordW-1:0] x0c, y0c, x1c, y1c;
  assign x0c = $signed({{(CoordW-StartW){1'b0}}, x0_q});
  assign y0c = $signed({{(CoordW-StartW){1'b0}}, y0_q});
  assign x1c = {{(CoordW-EndW){x1_q[EndW-1]}}, x1_q};
  assign y1c = {{(CoordW-EndW){y1_q[EndW-1]}}, y1_q};

  // line stepper
  logic signed [CoordW-1:0] x_q, y_q, diff_x, diff_y, abs_x, abs_y;
  logic [DeltaW-1:0]        dx_q, dy_q;
  logic                     sx_neg_q, sy_neg_q;
  logic signed [ErrW-1:0]   err_q, err_init;
  logic signed [ErrW:0]     e2, dx_e, dy_e, err_sum;
  logic                     c_x, c_y;

  assign diff_x   = x1c - x0c;
  assign diff_y   = y1c - y0c;
  assign abs_x    = diff_x[CoordW-1] ? -diff_x : diff_x;
  assign abs_y    = diff_y[CoordW-1] ? -diff_y : diff_y;
  assign err_init = $signed(ErrW'(abs_x[DeltaW-1:0])) - $signed(ErrW'(abs_y[DeltaW-1:0]));

  assign dx_e    = $signed({{(ErrW+1-DeltaW){1'b0}}, dx_q});
  assign dy_e    = $signed({{(ErrW+1-DeltaW){1'b0}}, dy_q});
  assign e2      = {err_q, 1'b0};
  assign c_x     = (e2 >= -dy_e);
  assign c_y     = (e2 <= dx_e);
  assign err_sum = {err_q[ErrW-1], err_q} - (c_x ? dy_e : '0) + (c_y ? dx_e : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      x_q      <= x0c;
      y_q      <= y0c;
      dx_q     <= abs_x[DeltaW-1:0];
      dy_q     <= abs_y[DeltaW-1:0];
      sx_neg_q <= !(x0c < x1c);
      sy_neg_q <= !(y0c < y1c);
      err_q    <= err_init;
    end else if (cmd_i.step) begin
      err_q <= err_sum[ErrW-1:0];
      if (c_x) x_q <= sx_neg_q ? x_q - CoordW'(1) : x_q + CoordW'(1);
      if (c_y) y_q <= sy_neg_q ? y_q - CoordW'(1) : y_q + CoordW'(1);
    end
  end

  // cell selection
  logic signed [CoordW-1:0] sel_x, sel_y;
  logic [AddrW-1:0]         sel_addr;
  logic                     sel_in_grid;

  always_comb begin
    unique case (cmd_i.addr_sel)
      SelEnd: begin
        sel_x = x1c;
        sel_y = y1c;
      end
      SelStart: begin
        sel_x = x0c;
        sel_y = y0c;
      end
      default: begin
        sel_x = x_q;
        sel_y = y_q;
      end
    endcase
  end

  assign sel_addr    = cell_addr(sel_x, sel_y);
  assign sel_in_grid = in_grid(sel_x, sel_y);

  // grid memory and clearing pass
  logic [OddsW-1:0] mem [GridDepth];
  logic [OddsW-1:0] rdata_q, wdata;
  logic [AddrW-1:0] clr_q, waddr;
  logic             we;
  logic signed [OddsW:0] hit_sum, miss_sum, hit_val, miss_val;

  assign hit_sum  = $signed({rdata_q[OddsW-1], rdata_q}) + $signed({2'b00, hit_q});
  assign miss_sum = $signed({rdata_q[OddsW-1], rdata_q}) - $signed({2'b00, miss_q});
  assign hit_val  = (hit_sum > OddsMax) ? OddsMax : hit_sum;
  assign miss_val = (miss_sum < OddsMin) ? OddsMin : miss_sum;

  assign we    = cmd_i.clear_wr | cmd_i.end_wr | cmd_i.ray_wr;
  assign waddr = cmd_i.clear_wr ? clr_q : sel_addr;
  assign wdata = cmd_i.clear_wr ? '0 :
                 cmd_i.end_wr   ? hit_val[OddsW-1:0] : miss_val[OddsW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[sel_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  // per-transaction results
  logic [OddsW-1:0] odds_q;
  logic [CntW-1:0]  cleared_q;
  logic             scored_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      odds_q    <= '0;
      cleared_q <= '0;
      scored_q  <= 1'b0;
    end else begin
      if (cmd_i.end_wr) scored_q <= 1'b1;
      if (cmd_i.ray_wr && cleared_q != CntMax) cleared_q <= cleared_q + CntW'(1);
      if (cmd_i.read_cap) odds_q <= sel_in_grid ? rdata_q : '0;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_read_odds_o       <= $signed(odds_q);
      out_cells_cleared_o   <= cleared_q;
      out_endpoint_scored_o <= scored_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.clear_last  = (clr_q == AddrW'(GridDepth - 1));
  assign status_o.req_read    = req_q;
  assign status_o.beyond      = beyond_q;
  assign status_o.sel_in_grid = sel_in_grid;
  assign status_o.walk_at_end = (x_q == x1c) && (y_q == y1c);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// ----- hw/rtl/ogru_port_chk.sv -----
// Port-level assertions for the occupancy grid ray update unit, with bind
`include "occupancy_grid_ray_update_unit_assert.svh"

module ogru_port_chk import ogru_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [OddsW-1:0]  out_read_odds_o,
  input logic [CntW-1:0]          out_cells_cleared_o,
  input logic                     out_endpoint_scored_o
);

  logic [OddsW+CntW:0] out_payload;
  logic                out_held, in_taken, read_seen, ray_counts_zero;

  assign out_payload     = {out_read_odds_o, out_cells_cleared_o, out_endpoint_scored_o};
  assign out_held        = out_valid_o && out_stall_i;
  assign in_taken        = in_valid_i && !in_stall_o;
  assign read_seen       = out_valid_o && (out_read_odds_o != '0);
  assign ray_counts_zero = (out_cells_cleared_o == '0) && !out_endpoint_scored_o;

  // stalled result transaction holds
  `OGRU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_payload))

  // a read result never carries ray counts
  `OGRU_ASSERT_NOW(a_read_only, clk_i, rst_ni, read_seen, ray_counts_zero)

  // busy right after taking a transaction
  `OGRU_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_taken, in_stall_o)

endmodule

bind occupancy_grid_ray_update_unit ogru_port_chk u_port_chk (.*);
